>>> rtl/rcfd_pkg.sv
// ---------------------------------------------------------------------------
// rcfd_pkg - shared types and constants for the serial frame channel decoder
// Frame geometry, register indexes, reset values and the channel join helper.
// ---------------------------------------------------------------------------
package rcfd_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned CHAN_W      = 10;
    localparam int unsigned FRAME_LEN   = 14;
    localparam int unsigned CNT_W       = 4;
    localparam int unsigned FIRST_USED  = 2;    // bytes 0 and 1 carry no channel
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned TDATA_W     = 64;   // 6 x 10 bits, padded to bytes

    localparam logic [CNT_W-1:0] LAST_IDX  = CNT_W'(FRAME_LEN - 1);

    localparam logic [BYTE_W-1:0] IDLE_BYTE        = 8'd255;
    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST   = 8'd24;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST  = 8'd0;
    localparam int unsigned       THROTTLE_RAW_BIT = 7;

    localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 1'b1;

    // frame bytes 2..13; byte 13 is the item that closes the frame
    typedef logic [FRAME_LEN-1:FIRST_USED][BYTE_W-1:0] t_frame;

    typedef struct packed {
        logic synced;
        logic frame_done;   // accepted item closes a frame this cycle
    } t_status;

    typedef struct packed {
        logic [CHAN_W-1:0] gear;
        logic [CHAN_W-1:0] throttle;
        logic [CHAN_W-1:0] rudder;
        logic [CHAN_W-1:0] elevator;
        logic [CHAN_W-1:0] flaps;
        logic [CHAN_W-1:0] aileron;
    } t_chan;

    function automatic logic [CHAN_W-1:0] join10(input logic [BYTE_W-1:0] hi,
                                                 input logic [BYTE_W-1:0] lo);
        join10 = {hi[1:0], lo};
    endfunction

endpackage

>>> rtl/rc_serial_frame_channel_decoder.sv
// ---------------------------------------------------------------------------
// rc_serial_frame_channel_decoder - radio-control serial frame decoder
// Locks on a two-byte sync pair, collects 14 frame bytes, emits six channels.
// ---------------------------------------------------------------------------
//  channel   dir   width  contents (low bit up)
//  s_axis    in    8      tdata: rx_byte
//  m_axis    out   64     tdata: aileron, flaps, elevator, rudder, throttle,
//                         gear (10 bits each), 4 zero bits
//  cfg       in    1+8    index 0 sync_first, index 1 sync_second
//
//  One byte per cycle. A frame result is registered when the item that
//  closes the frame is accepted and is valid in the following cycle.
//  Input stalls only while a result sits unread and the sink is not ready.
//  Synchronous active-low reset clears sync, count and result valid, and sets config to its reset values.
// ---------------------------------------------------------------------------
module rc_serial_frame_channel_decoder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [rcfd_pkg::BYTE_W-1:0]         s_axis_tdata,   // rx_byte
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // aileron, flaps, elevator, rudder, throttle, gear, zero pad
    output logic [rcfd_pkg::TDATA_W-1:0]        m_axis_tdata,
    input  logic                                i_cfg_we,
    input  logic [rcfd_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  logic [rcfd_pkg::BYTE_W-1:0]         i_cfg_data
);
    import rcfd_pkg::*;

    t_frame  frame;
    t_status status;
    t_chan   chan;
    logic    out_full;
    logic    in_accept;
    logic    out_take;

    assign s_axis_tready = !out_full || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_take      = out_full && m_axis_tready;

    rcfd_collect u_collect (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_accept   (in_accept),
        .i_byte     (s_axis_tdata),
        .o_frame    (frame),
        .o_status   (status)
    );

    rcfd_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (status.frame_done),
        .i_frame (frame),
        .i_take  (out_take),
        .o_full  (out_full),
        .o_chan  (chan)
    );

    assign m_axis_tvalid = out_full;
    assign m_axis_tdata  = {4'b0000, chan.gear, chan.throttle, chan.rudder,
                            chan.elevator, chan.flaps, chan.aileron};

    // a result shows up only right after a frame closes
    a_result_from_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(status.frame_done))
        else $error("result without a closing frame item");

    // closing a frame always drops sync
    a_unsync_after_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.frame_done |=> !status.synced)
        else $error("still synced after frame end");

    // a frame can only close while the result slot is free or draining
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.frame_done |-> (!out_full || m_axis_tready))
        else $error("result overwritten before it was taken");

endmodule

>>> rtl/rcfd_collect.sv
// ---------------------------------------------------------------------------
// rcfd_collect - sync search and frame byte capture
// Holds the config registers, the sync tracker and the frame byte registers.
// ---------------------------------------------------------------------------
module rcfd_collect (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rcfd_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  logic [rcfd_pkg::BYTE_W-1:0]         i_cfg_data,
    input  logic                                i_accept,
    input  logic [rcfd_pkg::BYTE_W-1:0]         i_byte,
    output rcfd_pkg::t_frame                    o_frame,
    output rcfd_pkg::t_status                   o_status
);
    import rcfd_pkg::*;

    logic [BYTE_W-1:0] r_sync_first;
    logic [BYTE_W-1:0] r_sync_second;
    logic [BYTE_W-1:0] r_prev,   n_prev;
    logic              r_synced, n_synced;
    logic [CNT_W-1:0]  r_count,  n_count;
    logic [BYTE_W-1:0] r_frame [FIRST_USED:FRAME_LEN-2];

    logic sync_hit;
    logic frame_done;

    assign sync_hit   = (r_prev == r_sync_first) && (i_byte == r_sync_second);
    assign frame_done = i_accept && r_synced && (r_count == LAST_IDX);

    always_comb begin
        n_prev   = r_prev;
        n_synced = r_synced;
        n_count  = r_count;
        if (i_accept) begin
            if (!r_synced) begin
                if (sync_hit) begin
                    n_synced = 1'b1;
                end else begin
                    n_prev = i_byte;
                end
            end else if (r_count == LAST_IDX) begin
                n_synced = 1'b0;
                n_count  = '0;
                n_prev   = IDLE_BYTE;
            end else begin
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= SYNC_FIRST_RST;
            r_sync_second <= SYNC_SECOND_RST;
            r_prev        <= IDLE_BYTE;
            r_synced      <= 1'b0;
            r_count       <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_SYNC_FIRST:  r_sync_first  <= i_cfg_data;
                    REG_SYNC_SECOND: r_sync_second <= i_cfg_data;
                    default: ;
                endcase
            end
            r_prev   <= n_prev;
            r_synced <= n_synced;
            r_count  <= n_count;
        end
    end

    // byte registers, one per frame position 2..12; no reset needed
    for (genvar k = FIRST_USED; k <= FRAME_LEN - 2; k++) begin : g_byte
        always_ff @(posedge i_clk) begin
            if (i_accept && r_synced && (r_count == CNT_W'(k))) begin
                r_frame[k] <= i_byte;
            end
        end
        assign o_frame[k] = r_frame[k];
    end

    assign o_frame[FRAME_LEN-1] = i_byte;

    assign o_status.synced     = r_synced;
    assign o_status.frame_done = frame_done;

endmodule

>>> rtl/rcfd_out.sv
// ---------------------------------------------------------------------------
// rcfd_out - channel assembly and result register
// Builds the six channels from a finished frame and holds them for the sink.
// ---------------------------------------------------------------------------
module rcfd_out (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_load,
    input  rcfd_pkg::t_frame           i_frame,
    input  logic                       i_take,
    output logic                       o_full,
    output rcfd_pkg::t_chan            o_chan
);
    import rcfd_pkg::*;

    t_chan n_chan;
    t_chan r_chan;
    logic  r_full;

    always_comb begin
        n_chan.aileron  = join10(i_frame[2],  i_frame[3]);
        n_chan.flaps    = join10(i_frame[4],  i_frame[5]);
        n_chan.elevator = join10(i_frame[6],  i_frame[7]);
        n_chan.rudder   = join10(i_frame[8],  i_frame[9]);
        n_chan.gear     = join10(i_frame[12], i_frame[13]);
        if (i_frame[10][THROTTLE_RAW_BIT]) begin
            n_chan.throttle = {2'b00, i_frame[10]};
        end else begin
            n_chan.throttle = join10(i_frame[10], i_frame[11]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (i_load) begin
            r_full <= 1'b1;
        end else if (i_take) begin
            r_full <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_chan <= n_chan;
        end
    end

    assign o_full = r_full;
    assign o_chan = r_chan;

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top - testbench for the radio-control serial frame channel decoder
// Drives byte streams with sync pairs, full, broken and truncated frames under
// several sync settings. Tracks lock state and frame bytes to predict the six
// channels, then checks each result field against the oldest prediction.
// ---------------------------------------------------------------------------
module tb_top;
    import rcfd_pkg::*;

    // Follows lock state and frame bytes, keeps the channel sets still due
    class frame_tracker;
        logic [BYTE_W-1:0] sync_first;
        logic [BYTE_W-1:0] sync_second;
        logic [BYTE_W-1:0] prev_byte;
        bit                locked;
        int unsigned       fill;
        logic [BYTE_W-1:0] frame_bytes [FRAME_LEN];
        t_chan             chan_due [$];
        int unsigned       errors;

        function new();
            sync_first  = SYNC_FIRST_RST;
            sync_second = SYNC_SECOND_RST;
            prev_byte   = IDLE_BYTE;
            locked      = 1'b0;
            fill        = 0;
            errors      = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
            case (idx)
                REG_SYNC_FIRST:  sync_first  = val;
                REG_SYNC_SECOND: sync_second = val;
                default: ;
            endcase
        endfunction

        function int unsigned due_count();
            return chan_due.size();
        endfunction

        function logic [CHAN_W-1:0] pair10(logic [BYTE_W-1:0] hi, logic [BYTE_W-1:0] lo);
            return {hi[1:0], lo};
        endfunction

        function void take_byte(logic [BYTE_W-1:0] b);
            t_chan c;
            if (!locked) begin
                // the second sync byte is dropped and leaves prev_byte as is
                if (prev_byte == sync_first && b == sync_second)
                    locked = 1'b1;
                else
                    prev_byte = b;
                return;
            end
            frame_bytes[fill] = b;
            fill++;
            if (fill < FRAME_LEN)
                return;
            c.aileron  = pair10(frame_bytes[2], frame_bytes[3]);
            c.flaps    = pair10(frame_bytes[4], frame_bytes[5]);
            c.elevator = pair10(frame_bytes[6], frame_bytes[7]);
            c.rudder   = pair10(frame_bytes[8], frame_bytes[9]);
            if (frame_bytes[10][THROTTLE_RAW_BIT])
                c.throttle = {2'b00, frame_bytes[10]};
            else
                c.throttle = pair10(frame_bytes[10], frame_bytes[11]);
            c.gear     = pair10(frame_bytes[12], frame_bytes[13]);
            chan_due.push_back(c);
            fill      = 0;
            locked    = 1'b0;
            prev_byte = IDLE_BYTE;
        endfunction

        task report(string what);
            errors++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        task cmp_field(string name, logic [CHAN_W-1:0] got, logic [CHAN_W-1:0] want);
            if (got !== want)
                report($sformatf("%s got %0d want %0d", name, got, want));
        endtask

        task check_channels(logic [TDATA_W-1:0] d);
            t_chan got;
            t_chan want;
            got = t_chan'(d[6*CHAN_W-1:0]);
            if (chan_due.size() == 0) begin
                report($sformatf("result %h with none due", d));
                return;
            end
            want = chan_due.pop_front();
            cmp_field("aileron",  got.aileron,  want.aileron);
            cmp_field("flaps",    got.flaps,    want.flaps);
            cmp_field("elevator", got.elevator, want.elevator);
            cmp_field("rudder",   got.rudder,   want.rudder);
            cmp_field("throttle", got.throttle, want.throttle);
            cmp_field("gear",     got.gear,     want.gear);
            if (d[TDATA_W-1:6*CHAN_W] !== '0)
                report($sformatf("pad bits %h", d[TDATA_W-1:6*CHAN_W]));
        endtask
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [BYTE_W-1:0]      s_axis_tdata;   // rx_byte
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // aileron, flaps, elevator, rudder, throttle, gear, zero pad
    logic [TDATA_W-1:0]     m_axis_tdata;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_addr;
    logic [BYTE_W-1:0]      i_cfg_data;

    frame_tracker tracker;
    int unsigned  bytes_sent;
    bit           in_gaps;
    bit           out_stalls;
    int unsigned  hold_asks;
    int unsigned  hold_done;

    rc_serial_frame_channel_decoder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // input notes go first so a same-edge result still finds its prediction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                tracker.take_byte(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                tracker.check_channels(m_axis_tdata);
        end
    end

    // sink side: random stalls, plus a long hold-off when one is asked for
    initial begin
        int unsigned stall_left;
        int unsigned r;
        m_axis_tready = 1'b0;
        stall_left    = 0;
        hold_done     = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                m_axis_tready = 1'b0;
                stall_left--;
            end else if (hold_asks != hold_done) begin
                hold_done++;
                m_axis_tready = 1'b0;
                stall_left    = 299;
            end else if (!out_stalls) begin
                m_axis_tready = 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    m_axis_tready = 1'b1;
                end else if (r < 95) begin
                    m_axis_tready = 1'b0;
                    stall_left    = $urandom_range(0, 2);
                end else begin
                    m_axis_tready = 1'b0;
                    stall_left    = $urandom_range(8, 40);
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!in_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [BYTE_W-1:0] pick_payload();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return tracker.sync_first;
            3:       return tracker.sync_second;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_sequence();
        int unsigned kind;
        int unsigned n;
        kind = $urandom_range(0, 9);
        if (kind <= 6) begin
            // well-formed frame, maybe after a little line noise
            n = $urandom_range(0, 3);
            repeat (n) send_byte(8'($urandom));
            send_byte(tracker.sync_first);
            send_byte(tracker.sync_second);
            repeat (FRAME_LEN) send_byte(pick_payload());
        end else if (kind == 7) begin
            send_byte(tracker.sync_first);
            n = $urandom_range(1, 5);
            repeat (n) send_byte(8'($urandom));
        end else if (kind == 8) begin
            n = $urandom_range(1, 10);
            repeat (n) send_byte(8'($urandom));
        end else begin
            // cut short: the following bytes finish this frame
            send_byte(tracker.sync_first);
            send_byte(tracker.sync_second);
            n = $urandom_range(0, FRAME_LEN - 1);
            repeat (n) send_byte(pick_payload());
        end
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_addr = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        tracker.write_reg(idx, val);
    endtask

    // bytes that end no frame may still be in flight; allow the result latency
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (tracker.due_count() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        logic [BYTE_W-1:0] frame_a [FRAME_LEN];
        logic [BYTE_W-1:0] reg_first;
        logic [BYTE_W-1:0] reg_second;
        int unsigned       target;
        tracker       = new();
        bytes_sent    = 0;
        in_gaps       = 1'b1;
        out_stalls    = 1'b1;
        hold_asks     = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_data    = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset sync pair: no match, repeated first byte, then lock
        send_byte(8'h00);
        send_byte(SYNC_FIRST_RST);
        send_byte(SYNC_FIRST_RST);
        send_byte(SYNC_SECOND_RST);
        // extreme channels, sync pair as data, raw throttle
        frame_a = '{8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, SYNC_FIRST_RST,
                    SYNC_SECOND_RST, 8'h03, 8'h00, 8'h80, 8'h55, 8'hFE, 8'hFF};
        foreach (frame_a[k]) send_byte(frame_a[k]);
        // previous byte is idle again, so this alone must not lock
        send_byte(SYNC_SECOND_RST);

        for (int p = 0; p < 8; p++) begin
            wait_idle();
            case (p)
                0: begin reg_first = SYNC_FIRST_RST; reg_second = SYNC_SECOND_RST; end
                1: begin reg_first = 8'hFF; reg_second = 8'hFF; end
                2: begin reg_first = 8'h00; reg_second = 8'h00; end
                3: begin reg_first = 8'h00; reg_second = 8'hFF; end
                4: begin reg_first = 8'hFF; reg_second = 8'h00; end
                7: begin reg_first = SYNC_FIRST_RST; reg_second = SYNC_SECOND_RST; end
                default: begin reg_first = 8'($urandom); reg_second = 8'($urandom); end
            endcase
            cfg_write(REG_SYNC_FIRST, reg_first);
            cfg_write(REG_SYNC_SECOND, reg_second);
            in_gaps    = (p != 2);
            out_stalls = (p != 2);
            if (p == 4)
                hold_asks++;
            target = bytes_sent + 205;
            while (bytes_sent < target) send_sequence();
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (tracker.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
